@@ src/bsc_pkg.sv @@
// shared types, codes and arithmetic helpers of the binary-swap compositor
package bsc_pkg;

	localparam int FRAC_BITS = 15;
	localparam int PIX_W     = 16;
	localparam int CH_N      = 4;
	localparam logic [PIX_W-1:0] ONE_VAL = 16'h8000;
	localparam logic [31:0] HALF_VAL = 32'h0000_4000;
	localparam logic [2:0] SIDE_RST  = 3'd6;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [CH_N-1:0][PIX_W-1:0] rgba_t;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_SEND = 2'd1,
		CMD_RECV = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_SIDE_LOG2   = 2'd0,
		CFG_LEVEL_COUNT = 2'd1,
		CFG_OVER_MASK   = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// clamp a raw input value to one
	function automatic pix_t sat_in(input logic [PIX_W-1:0] v);
		return (v > ONE_VAL) ? ONE_VAL : v;
	endfunction

	// saturating sum of two values up to one
	function automatic pix_t sat_add(input pix_t a, input pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, ONE_VAL}) ? ONE_VAL : s[PIX_W-1:0];
	endfunction

	// side log2 in use, held to 1..maxl
	function automatic logic [3:0] eff_log2(input logic [2:0] s, input logic [3:0] maxl);
		logic [3:0] r;
		r = {1'b0, s};
		if (r == 4'd0) r = 4'd1;
		if (r > maxl) r = maxl;
		return r;
	endfunction

endpackage

@@ src/bsc_ram.sv @@
// generic single-port-write, registered-read memory
module bsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bsc_mul.sv @@
// shared fixed-point multiplier with round to nearest and a registered product
module bsc_mul (
	input  logic          clk,
	input  bsc_pkg::pix_t op_a,
	input  bsc_pkg::pix_t op_b,
	output bsc_pkg::pix_t product
);

	logic [31:0] full;
	logic [31:0] rounded;

	assign full    = 32'(op_a) * 32'(op_b);
	assign rounded = (full + bsc_pkg::HALF_VAL) >> bsc_pkg::FRAC_BITS;

	always_ff @(posedge clk) begin
		product <= rounded[bsc_pkg::PIX_W-1:0];
	end

endmodule

@@ src/binary_swap_compositor.sv @@
// top level of the binary-swap compositor: command sequencer, region state and pixel store
//
// One compositing node over a square RGBA tile (Q1.15, one = 32768). A command
// is taken when start is high and busy is low; its single result, if any, is
// shown for one cycle with done high and cannot be held off. Load and out-of-range or
// finished-level answers come straight from the decode state; read and send pass
// through decode, one registered memory read and the output state; receive passes through
// decode, the memory read, seven products through the one shared multiplier and write-back.
// The done cycle of one transaction may carry the start of the next. A send
// after the whole send half went out gives no result. Configuration writes are
// taken at once and belong to idle periods; writing side_log2 restarts at level 0.
module binary_swap_compositor #(
	parameter int SIDE_LOG2 = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        start,
	input  logic [1:0]  command,
	input  logic [5:0]  pos_x,
	input  logic [5:0]  pos_y,
	input  logic [15:0] in_red,
	input  logic [15:0] in_green,
	input  logic [15:0] in_blue,
	input  logic [15:0] in_alpha,
	output logic        busy,
	output logic        done,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [15:0] out_alpha,
	output logic [5:0]  out_x,
	output logic [5:0]  out_y,
	output logic        last,
	output logic [1:0]  status
);

	localparam int CW      = SIDE_LOG2;
	localparam int AW      = 2 * CW;
	localparam int DEPTH   = 1 << AW;
	localparam int RST_EFF = (SIDE_LOG2 < 6) ? SIDE_LOG2 : 6;
	localparam logic [CW-1:0] RST_HIGH = CW'((1 << RST_EFF) - 1);

	typedef struct packed {
		logic [CW-1:0] lx;
		logic [CW-1:0] hx;
		logic [CW-1:0] ly;
		logic [CW-1:0] hy;
	} rect_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_OUT,
		S_MUL,
		S_WB
	} state_t;

	state_t state_q;

	// configuration
	logic [2:0]  side_log2_q;
	logic [3:0]  level_count_q;
	logic [11:0] over_mask_q;

	// compositing progress
	rect_t         region_q;
	logic [3:0]    level_q;
	logic [CW-1:0] scx_q, scy_q, rcx_q, rcy_q;
	logic          send_begun_q;

	// captured transaction
	logic [1:0]     cmd_q;
	logic [5:0]     px_q, py_q;
	bsc_pkg::rgba_t v_q;
	logic           over_q;
	logic [AW-1:0]  addr_q;
	logic [2:0]     step_q;
	bsc_pkg::rgba_t acc_q;

	// result registers
	logic           done_q;
	bsc_pkg::rgba_t res_c_q;
	logic [5:0]     res_x_q, res_y_q;
	logic           res_last_q;
	logic [1:0]     res_status_q;

	// derived view of the current level
	logic [3:0]    eff_now;
	logic [3:0]    eff_new;
	logic [4:0]    levels_now;
	logic [4:0]    level_cap;
	logic [15:0]   mask_ext;
	logic          over_now;
	logic [CW-1:0] mid_x, mid_y;
	rect_t         keep_r, send_r;
	logic [CW-1:0] sx, sy, kx, ky;
	logic          send_last, recv_last;
	logic          out_of_range;
	logic          levels_done;
	logic [AW-1:0] addr_d;
	logic [CW-1:0] restart_high;

	// memory and multiplier hookup
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	bsc_pkg::rgba_t ram_wdata;
	bsc_pkg::rgba_t ram_rdata;
	bsc_pkg::rgba_t front, back;
	bsc_pkg::pix_t  t_val;
	bsc_pkg::pix_t  mul_a, mul_b, mul_p;

	assign eff_now    = bsc_pkg::eff_log2(side_log2_q, 4'(SIDE_LOG2));
	assign eff_new    = bsc_pkg::eff_log2(cfg_data[2:0], 4'(SIDE_LOG2));
	assign level_cap  = {eff_now, 1'b0};
	assign levels_now = ({1'b0, level_count_q} < level_cap) ? {1'b0, level_count_q} : level_cap;
	assign levels_done = ({1'b0, level_q} >= levels_now);
	assign restart_high = {CW{1'b1}} >> (4'(CW) - eff_new);

	assign mask_ext = {4'b0000, over_mask_q};
	assign over_now = mask_ext[level_q];

	// split point rounded up so both halves stay nonempty
	assign mid_x = CW'(({1'b0, region_q.lx} + {1'b0, region_q.hx} + (CW+1)'(1)) >> 1);
	assign mid_y = CW'(({1'b0, region_q.ly} + {1'b0, region_q.hy} + (CW+1)'(1)) >> 1);

	// x split at even levels, y split at odd levels
	always_comb begin
		keep_r = region_q;
		send_r = region_q;
		if (!level_q[0]) begin
			if (over_now) begin
				keep_r.lx = mid_x;
				send_r.hx = mid_x - CW'(1);
			end else begin
				keep_r.hx = mid_x - CW'(1);
				send_r.lx = mid_x;
			end
		end else begin
			if (over_now) begin
				keep_r.hy = mid_y - CW'(1);
				send_r.ly = mid_y;
			end else begin
				keep_r.ly = mid_y;
				send_r.hy = mid_y - CW'(1);
			end
		end
	end

	assign sx = send_r.lx + scx_q;
	assign sy = send_r.ly + scy_q;
	assign kx = keep_r.lx + rcx_q;
	assign ky = keep_r.ly + rcy_q;
	assign send_last = (scx_q == send_r.hx - send_r.lx) && (scy_q == send_r.hy - send_r.ly);
	assign recv_last = (rcx_q == keep_r.hx - keep_r.lx) && (rcy_q == keep_r.hy - keep_r.ly);

	// load and read bounds against the side in use
	assign out_of_range = ((px_q >> eff_now) != 6'd0) || ((py_q >> eff_now) != 6'd0);

	// store address of the pixel this transaction touches
	always_comb begin
		unique case (cmd_q)
			bsc_pkg::CMD_SEND: addr_d = {sy, sx};
			bsc_pkg::CMD_RECV: addr_d = {ky, kx};
			default:           addr_d = {CW'(py_q), CW'(px_q)};
		endcase
	end

	// compositing operands: local pixel is front when the over bit is set
	assign front = over_q ? ram_rdata : v_q;
	assign back  = over_q ? v_q : ram_rdata;
	assign t_val = bsc_pkg::pix_t'({1'b0, bsc_pkg::ONE_VAL} - {1'b0, front[3]});

	// product schedule: three premultiplies, then alpha and colors by (one - front alpha)
	always_comb begin
		unique case (step_q)
			3'd0: begin mul_a = back[0]; mul_b = back[3]; end
			3'd1: begin mul_a = back[1]; mul_b = back[3]; end
			3'd2: begin mul_a = back[2]; mul_b = back[3]; end
			3'd3: begin mul_a = back[3]; mul_b = t_val; end
			3'd4: begin mul_a = acc_q[0]; mul_b = t_val; end
			3'd5: begin mul_a = acc_q[1]; mul_b = t_val; end
			3'd6: begin mul_a = acc_q[2]; mul_b = t_val; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	bsc_mul u_mul (
		.clk     (clk),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.product (mul_p)
	);

	// load writes during decode, receive writes back its blended pixel
	assign ram_we    = ((state_q == S_DECODE) && (cmd_q == bsc_pkg::CMD_LOAD) && !out_of_range)
	                   || (state_q == S_WB);
	assign ram_waddr = (state_q == S_WB) ? addr_q : addr_d;
	assign ram_wdata = (state_q == S_WB) ? acc_q : v_q;

	bsc_ram #(
		.WIDTH (bsc_pkg::CH_N * bsc_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			side_log2_q   <= bsc_pkg::SIDE_RST;
			level_count_q <= '0;
			over_mask_q   <= '0;
			region_q      <= '{lx: '0, hx: RST_HIGH, ly: '0, hy: RST_HIGH};
			level_q       <= '0;
			scx_q         <= '0;
			scy_q         <= '0;
			rcx_q         <= '0;
			rcy_q         <= '0;
			send_begun_q  <= 1'b0;
			cmd_q         <= '0;
			px_q          <= '0;
			py_q          <= '0;
			v_q           <= '0;
			over_q        <= 1'b0;
			addr_q        <= '0;
			step_q        <= '0;
			acc_q         <= '0;
			done_q        <= 1'b0;
			res_c_q       <= '0;
			res_x_q       <= '0;
			res_y_q       <= '0;
			res_last_q    <= 1'b0;
			res_status_q  <= bsc_pkg::ST_OK;
		end else begin
			done_q <= 1'b0;

			// register writes, only while idle: the user must keep to this, the block does not enforce it
			if (cfg_we) begin
				unique case (cfg_index)
					bsc_pkg::CFG_SIDE_LOG2: begin
						side_log2_q  <= cfg_data[2:0];
						region_q     <= '{lx: '0, hx: restart_high, ly: '0, hy: restart_high};
						level_q      <= '0;
						scx_q        <= '0;
						scy_q        <= '0;
						rcx_q        <= '0;
						rcy_q        <= '0;
						send_begun_q <= 1'b0;
					end
					bsc_pkg::CFG_LEVEL_COUNT: level_count_q <= cfg_data[3:0];
					bsc_pkg::CFG_OVER_MASK:   over_mask_q   <= cfg_data;
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= command;
						px_q    <= pos_x;
						py_q    <= pos_y;
						v_q[0]  <= bsc_pkg::sat_in(in_red);
						v_q[1]  <= bsc_pkg::sat_in(in_green);
						v_q[2]  <= bsc_pkg::sat_in(in_blue);
						v_q[3]  <= bsc_pkg::sat_in(in_alpha);
						state_q <= S_DECODE;
					end
				end

				S_DECODE: begin
					addr_q       <= addr_d;
					over_q       <= over_now;
					res_last_q   <= 1'b0;
					res_status_q <= bsc_pkg::ST_OK;
					if ((cmd_q == bsc_pkg::CMD_LOAD) || (cmd_q == bsc_pkg::CMD_READ)) begin
						res_x_q <= px_q;
						res_y_q <= py_q;
						if (out_of_range) begin
							res_c_q      <= '0;
							res_status_q <= bsc_pkg::ST_RANGE;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else if (cmd_q == bsc_pkg::CMD_LOAD) begin
							res_c_q <= v_q;
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_READ;
						end
					end else if (levels_done) begin
						// every level composited
						res_c_q      <= '0;
						res_x_q      <= '0;
						res_y_q      <= '0;
						res_status_q <= bsc_pkg::ST_DONE;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else if (cmd_q == bsc_pkg::CMD_SEND) begin
						if (send_begun_q) begin
							// send half already streamed: no result
							state_q <= S_IDLE;
						end else begin
							res_x_q    <= 6'(sx);
							res_y_q    <= 6'(sy);
							res_last_q <= send_last;
							if (send_last) begin
								scx_q        <= '0;
								scy_q        <= '0;
								send_begun_q <= 1'b1;
							end else if (scx_q == send_r.hx - send_r.lx) begin
								scx_q <= '0;
								scy_q <= scy_q + CW'(1);
							end else begin
								scx_q <= scx_q + CW'(1);
							end
							state_q <= S_READ;
						end
					end else begin
						res_x_q    <= 6'(kx);
						res_y_q    <= 6'(ky);
						res_last_q <= recv_last;
						if (recv_last) begin
							// kept half becomes the new region
							region_q     <= keep_r;
							level_q      <= level_q + 4'd1;
							scx_q        <= '0;
							scy_q        <= '0;
							rcx_q        <= '0;
							rcy_q        <= '0;
							send_begun_q <= 1'b0;
						end else if (rcx_q == keep_r.hx - keep_r.lx) begin
							rcx_q <= '0;
							rcy_q <= rcy_q + CW'(1);
						end else begin
							rcx_q <= rcx_q + CW'(1);
						end
						state_q <= S_READ;
					end
				end

				S_READ: begin
					step_q  <= '0;
					state_q <= (cmd_q == bsc_pkg::CMD_RECV) ? S_MUL : S_OUT;
				end

				S_OUT: begin
					res_c_q <= ram_rdata;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end

				S_MUL: begin
					step_q <= step_q + 3'd1;
					unique case (step_q)
						3'd1: acc_q[0] <= mul_p;
						3'd2: acc_q[1] <= mul_p;
						3'd3: acc_q[2] <= mul_p;
						3'd4: acc_q[3] <= bsc_pkg::sat_add(front[3], mul_p);
						3'd5: acc_q[0] <= bsc_pkg::sat_add(front[0], mul_p);
						3'd6: acc_q[1] <= bsc_pkg::sat_add(front[1], mul_p);
						3'd7: begin
							acc_q[2] <= bsc_pkg::sat_add(front[2], mul_p);
							state_q  <= S_WB;
						end
						default: ;
					endcase
				end

				S_WB: begin
					res_c_q <= acc_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign out_red   = res_c_q[0];
	assign out_green = res_c_q[1];
	assign out_blue  = res_c_q[2];
	assign out_alpha = res_c_q[3];
	assign out_x     = res_x_q;
	assign out_y     = res_y_q;
	assign last      = res_last_q;
	assign status    = res_status_q;

endmodule

@@ src/bsc_checker.sv @@
// port-level checks of the compositor and their binding
module bsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] out_red,
	input logic [15:0] out_alpha,
	input logic [5:0]  out_x,
	input logic        last,
	input logic [1:0]  status
);

	// a taken transaction raises busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// results only come out of work in progress
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result strobe without a transaction");

	// error and finished answers never flag a last pixel
	a_last_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != bsc_pkg::ST_OK)) |-> !last)
		else $error("last set on a non-ok result");

	// finished answers carry zero payload
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == bsc_pkg::ST_DONE)) |-> ((out_red == 16'd0) && (out_alpha == 16'd0)
			&& (out_x == 6'd0)))
		else $error("finished answer with nonzero payload");

endmodule

bind binary_swap_compositor bsc_checker u_bsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.out_red   (out_red),
	.out_alpha (out_alpha),
	.out_x     (out_x),
	.last      (last),
	.status    (status)
);
